@@ sv/bftr_pkg.sv @@
// Shared types and constants of the bitmap font text rasterizer.
package bftr_pkg;

  localparam int MAX_TEXT_BYTES    = 40;
  localparam int GLYPH_ROWS        = 24;
  localparam int WIDE_FONT_BYTES   = 636192;
  localparam int NARROW_FONT_BYTES = 9216;

  // wide font: three bytes per glyph row, kept as three byte lanes of one word
  localparam int WIDE_WORDS   = WIDE_FONT_BYTES / 3;
  localparam int WIDE_AW      = $clog2(WIDE_WORDS);
  // narrow font: even and odd byte addresses in two banks
  localparam int NARROW_BANK  = NARROW_FONT_BYTES / 2;
  localparam int NARROW_AW    = $clog2(NARROW_BANK);
  localparam int NARROW_BW    = $clog2(NARROW_FONT_BYTES);

  // floor(x / 3) = (x * DIV3_RECIP) >> DIV3_SHIFT for any 20-bit x
  localparam logic [19:0] DIV3_RECIP = 20'd699051;
  localparam int          DIV3_SHIFT = 21;

  localparam logic [7:0] LEAD_THRESHOLD = 8'hA0;
  localparam logic [6:0] GRID_FIRST     = 7'd33;
  localparam logic [6:0] GRID_LAST      = 7'd126;
  localparam logic [6:0] GRID_SIZE      = 7'd94;
  localparam logic [5:0] COUNT_MAX      = 6'd63;

  localparam logic [1:0] FUNC_WIDE_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_NARROW_LOAD = 2'd1;
  localparam logic [1:0] FUNC_TEXT        = 2'd2;

  localparam logic [1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [31:0] TEXT_COLOR_RST   = 32'hFFFF_FFFF;
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd24;

  localparam int ROW_W = $clog2(GLYPH_ROWS);

  typedef struct packed {
    logic [1:0]  func;
    logic [19:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  text_byte;
    logic        text_start;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [23:0] ink_bits;
    logic [23:0] write_mask;
    logic [31:0] fore_color;
    logic        last_row;
  } out_res_t;

  typedef struct packed {
    logic             decode;
    logic             issue;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic glyph;
    logic advance;
  } sts_t;

endpackage

@@ sv/bftr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bftr_ctrl.sv @@
// Controller: request intake, decode step and glyph row sequencing.
module bftr_ctrl import bftr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             issue;

  assign issue = (state_r == ST_EMIT) && sts.advance;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        row_nxt   = '0;
        state_nxt = sts.glyph ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (issue) begin
          row_nxt = row_r + 1'b1;
          if (row_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.decode = (state_r == ST_DECODE);
  assign cmd.issue  = issue;
  assign cmd.row    = row_r;

endmodule

@@ sv/bftr_datapath.sv @@
// Datapath: text state, font stores, row read stage and result register.
module bftr_datapath import bftr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  in_req_t     in_req,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res
);

  // configuration
  logic [31:0] text_color_r;
  logic [12:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= TEXT_COLOR_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR:   text_color_r   <= cfg_wdata;
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // request register
  in_req_t req_r;

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req;
    end
  end

  // text state
  logic [9:0] pen_r, pen_nxt;
  logic [5:0] count_r, count_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic       pend_r, pend_nxt;

  logic       is_text;
  logic [9:0] pen_eff;
  logic [5:0] cnt_eff;
  logic       pend_eff;
  logic       glyph_wide, glyph_narrow, glyph;
  logic [6:0] lead7, part7;
  logic       grid_ok;
  logic [13:0] grid_prod;
  logic [13:0] glyph_idx;
  logic [WIDE_AW-1:0]   wbase;
  logic [NARROW_BW-1:0] nbase;
  logic [4:0]  gw;
  logic [23:0] col_mask;
  logic [12:0] col_x;

  assign is_text  = cmd.decode && (req_r.func == FUNC_TEXT);
  assign pen_eff  = req_r.text_start ? '0 : pen_r;
  assign cnt_eff  = req_r.text_start ? '0 : count_r;
  assign pend_eff = pend_r && !req_r.text_start;

  assign glyph_wide   = pend_eff;
  assign glyph_narrow = !pend_eff && (cnt_eff < 6'(MAX_TEXT_BYTES)) &&
                        (req_r.text_byte <= LEAD_THRESHOLD);
  assign glyph        = glyph_wide || glyph_narrow;

  assign lead7   = lead_r[6:0];
  assign part7   = req_r.text_byte[6:0];
  assign grid_ok = (lead7 >= GRID_FIRST) && (lead7 <= GRID_LAST) &&
                   (part7 >= GRID_FIRST) && (part7 <= GRID_LAST);

  // glyph index on the 94x94 grid, then 24 words of three bytes per glyph
  assign grid_prod = 14'(lead7 - GRID_FIRST) * 14'(GRID_SIZE);
  assign glyph_idx = grid_prod + 14'(part7 - GRID_FIRST);
  assign wbase     = (WIDE_AW'(glyph_idx) << 4) + (WIDE_AW'(glyph_idx) << 3);
  assign nbase     = (NARROW_BW'(req_r.text_byte) << 5) +
                     (NARROW_BW'(req_r.text_byte) << 2);

  assign gw = glyph_wide ? 5'd24 : 5'd12;

  always_comb begin
    for (int m = 0; m < 24; m++) begin
      col_x = 13'(pen_eff) + 13'(m);
      col_mask[23 - m] = (5'(m) < gw) && (col_x < frame_width_r);
    end
  end

  always_comb begin
    pen_nxt   = pen_r;
    count_nxt = count_r;
    lead_nxt  = lead_r;
    pend_nxt  = pend_r;
    if (is_text) begin
      pen_nxt   = pen_eff;
      count_nxt = cnt_eff;
      pend_nxt  = pend_eff;
      if (pend_eff) begin
        pend_nxt = 1'b0;
        if (cnt_eff < COUNT_MAX) begin
          count_nxt = cnt_eff + 1'b1;
        end
      end else if (cnt_eff < 6'(MAX_TEXT_BYTES)) begin
        count_nxt = cnt_eff + 1'b1;
        if (req_r.text_byte > LEAD_THRESHOLD) begin
          lead_nxt = req_r.text_byte;
          pend_nxt = 1'b1;
        end
      end
      if (glyph) begin
        pen_nxt = pen_eff + 10'(gw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r   <= '0;
      count_r <= '0;
      lead_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      pen_r   <= pen_nxt;
      count_r <= count_nxt;
      lead_r  <= lead_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // glyph registers, loaded at decode
  logic [9:0]           gpen_r;
  logic                 gwide_r, gvalid_r;
  logic [23:0]          gmask_r;
  logic [WIDE_AW-1:0]   wbase_r;
  logic [NARROW_BW-1:0] nbase_r;

  always_ff @(posedge clk) begin
    if (is_text && glyph) begin
      gpen_r   <= pen_eff;
      gwide_r  <= glyph_wide;
      gvalid_r <= grid_ok;
      gmask_r  <= col_mask;
      wbase_r  <= wbase;
      nbase_r  <= nbase;
    end
  end

  assign sts.glyph = is_text && glyph;

  // font loads
  logic [39:0]        div_prod;
  logic [WIDE_AW-1:0] wide_word;
  logic [19:0]        wide_rem;
  logic               wide_we, narrow_we;
  logic [2:0]         lane_we;

  assign div_prod  = 40'(req_r.font_addr) * 40'(DIV3_RECIP);
  assign wide_word = div_prod[DIV3_SHIFT +: WIDE_AW];
  assign wide_rem  = req_r.font_addr - ((20'(wide_word) << 1) + 20'(wide_word));
  assign wide_we   = cmd.decode && (req_r.func == FUNC_WIDE_LOAD) &&
                     (req_r.font_addr < 20'(WIDE_FONT_BYTES));
  assign narrow_we = cmd.decode && (req_r.func == FUNC_NARROW_LOAD) &&
                     (req_r.font_addr < 20'(NARROW_FONT_BYTES));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_we[k] = wide_we && (wide_rem[1:0] == 2'(k));
    end
  end

  // row read addresses
  logic [WIDE_AW-1:0]   wide_raddr;
  logic [6:0]           row3;
  logic [NARROW_BW-1:0] row_a0;
  logic [NARROW_AW-1:0] even_raddr, odd_raddr;

  assign wide_raddr = wbase_r + WIDE_AW'(cmd.row);
  assign row3       = (7'(cmd.row) << 1) + 7'(cmd.row);
  assign row_a0     = nbase_r + NARROW_BW'(row3[6:1]);
  assign even_raddr = NARROW_AW'((row_a0 + 1'b1) >> 1);
  assign odd_raddr  = row_a0[NARROW_BW-1:1];

  logic [7:0] wide_d [3];
  logic [7:0] even_d, odd_d;

  for (genvar k = 0; k < 3; k++) begin : g_wide
    bftr_ram #(.WIDTH(8), .DEPTH(WIDE_WORDS)) u_wide (
      .clk   (clk),
      .we    (lane_we[k]),
      .waddr (wide_word),
      .wdata (req_r.font_byte),
      .re    (cmd.issue),
      .raddr (wide_raddr),
      .rdata (wide_d[k])
    );
  end

  bftr_ram #(.WIDTH(8), .DEPTH(NARROW_BANK)) u_narrow_even (
    .clk   (clk),
    .we    (narrow_we && !req_r.font_addr[0]),
    .waddr (req_r.font_addr[NARROW_AW:1]),
    .wdata (req_r.font_byte),
    .re    (cmd.issue),
    .raddr (even_raddr),
    .rdata (even_d)
  );

  bftr_ram #(.WIDTH(8), .DEPTH(NARROW_BANK)) u_narrow_odd (
    .clk   (clk),
    .we    (narrow_we && req_r.font_addr[0]),
    .waddr (req_r.font_addr[NARROW_AW:1]),
    .wdata (req_r.font_byte),
    .re    (cmd.issue),
    .raddr (odd_raddr),
    .rdata (odd_d)
  );

  // read stage: row tags travel beside the RAM read data
  logic             advance;
  logic             s1_valid_r;
  logic [9:0]       s1_pen_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_wide_r, s1_gvalid_r, s1_odd_r;
  logic [23:0]      s1_mask_r;
  logic             out_valid_r;
  out_res_t         out_res_r;

  assign advance     = !out_valid_r || !out_stall;
  assign sts.advance = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_pen_r    <= gpen_r;
      s1_row_r    <= cmd.row;
      s1_wide_r   <= gwide_r;
      s1_gvalid_r <= gvalid_r;
      s1_odd_r    <= row_a0[0];
      s1_mask_r   <= (13'(cmd.row) < frame_height_r) ? gmask_r : '0;
    end
  end

  // assemble the row bits
  logic [7:0]  hi_byte, lo_byte;
  logic [11:0] narrow_bits;
  logic [23:0] ink;

  assign hi_byte     = s1_odd_r ? odd_d  : even_d;
  assign lo_byte     = s1_odd_r ? even_d : odd_d;
  assign narrow_bits = s1_row_r[0] ? {hi_byte[3:0], lo_byte} : {hi_byte, lo_byte[7:4]};

  always_comb begin
    if (s1_wide_r) begin
      ink = s1_gvalid_r ? {wide_d[0], wide_d[1], wide_d[2]} : '0;
    end else begin
      ink = {narrow_bits, 12'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_res_r.pixel_x    <= s1_pen_r;
      out_res_r.pixel_y    <= 5'(s1_row_r);
      out_res_r.ink_bits   <= ink;
      out_res_r.write_mask <= s1_mask_r;
      out_res_r.fore_color <= text_color_r;
      out_res_r.last_row   <= (s1_row_r == ROW_W'(GLYPH_ROWS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ sv/bitmap_font_text_rasterizer_unit.sv @@
// Top level of the bitmap font text rasterizer.
// Loads font bytes into a 24x24 double-byte store and a 12x24 single-byte store, then
// turns a text byte stream into glyph rows: each glyph gives 24 requests carrying the
// pen x, row, ink bits (bit 23 leftmost), a write mask clipped to the frame, the text
// color and a last-row flag. A font load, a lead byte or a byte past the 40-byte
// string cap passes only through intake and decode. A byte that draws a glyph goes
// through intake, decode, then 24 row reads, one per cycle, set by the single read
// port of the font memories; a stalled output holds the row pipeline. Results move
// through a read stage and an output register, so the last rows of a glyph may still
// wait while the next request is taken. Font memories are not cleared after reset.
module bitmap_font_text_rasterizer_unit import bftr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bftr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bftr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_valid && !in_stall),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

@@ sv/bftr_checker.sv @@
// Port-level checks of the rasterizer, bound to the top level.
module bftr_checker import bftr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_res
);

  // hold a stalled request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.pixel_y < 5'(GLYPH_ROWS))
    else $error("row number out of range");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.last_row == (out_res.pixel_y == 5'(GLYPH_ROWS - 1))))
    else $error("last row flag does not match row number");

  // rows of a glyph come in order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_res.last_row ##1 out_valid |->
      out_res.pixel_y == $past(out_res.pixel_y) + 5'd1)
    else $error("glyph rows out of order");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_font_text_rasterizer_unit bftr_checker u_bftr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
